### hdl/bbl_pkg.sv
// Shared constants, types and arithmetic helpers for the nine-tap box blur.
package bbl_pkg;

	// Frame limits and filter shape
	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 4096;
	localparam int RADIUS     = 4;
	localparam int SPAN       = 2 * RADIUS;
	localparam int TAPS       = 2 * RADIUS + 1;

	// Field widths
	localparam int CH_W   = 8;
	localparam int PIX_W  = 3 * CH_W;
	localparam int WORD_W = SPAN * PIX_W;
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int SLOT_W = $clog2(SPAN);
	localparam int IW_W   = 12;
	localparam int LINE_W = 13;
	localparam int CMP_W  = 16;

	// APB port
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	// Reciprocal divide by TAPS, exact for every sum below 2**SUM_W
	localparam int SUM_W     = $clog2(TAPS * 255 + 1);
	localparam int DIV_SHIFT = SUM_W + 4;
	localparam int DIV_MULT  = (2 ** DIV_SHIFT + TAPS - 1) / TAPS;
	localparam int MULT_W    = $clog2(DIV_MULT + 1);
	localparam int PROD_W    = SUM_W + MULT_W;

	typedef logic [PIX_W-1:0]  pix_t;
	typedef logic [WORD_W-1:0] word_t;
	typedef logic [COL_W-1:0]  col_t;
	typedef logic [ROW_W-1:0]  row_t;
	typedef logic [SUM_W-1:0]  sum_t;

	// Register indexes (byte address / 4)
	typedef enum logic [1:0] {
		REG_DIRECTION  = 2'd0,
		REG_WIDTH      = 2'd1,
		REG_FIRST_LINE = 2'd2,
		REG_END_LINE   = 2'd3
	} reg_idx_t;

	// Configuration as seen by the datapath
	typedef struct packed {
		logic              blur_direction;
		logic [IW_W-1:0]   image_width;
		logic [LINE_W-1:0] first_line;
		logic [LINE_W-1:0] end_line;
	} cfg_t;

	// Centre pixel plus all SPAN taps of one channel
	function automatic sum_t chan_sum(input pix_t px, input word_t taps, input int k);
		sum_t acc;
		acc = SUM_W'(px[CH_W*k +: CH_W]);
		for (int s = 0; s < SPAN; s++) begin
			acc = acc + SUM_W'(taps[s*PIX_W + CH_W*k +: CH_W]);
		end
		return acc;
	endfunction

	// floor(x / TAPS) by multiply and shift
	function automatic logic [CH_W-1:0] div_taps(input sum_t x);
		logic [PROD_W-1:0] p;
		p = PROD_W'(x) * PROD_W'(DIV_MULT);
		return p[DIV_SHIFT +: CH_W];
	endfunction

endpackage

### hdl/box_blur_nine_tap_line_or_column.sv
// Top level of the nine-tap box blur over a raster pixel stream.
//
// Pixels arrive in raster order on the pixel channel (pixel_valid, pixel_stall);
// start_of_frame marks column 0, row 0 and resets the position counters.
// Each channel is averaged over nine taps, floor(sum/9), along the row
// (blur_direction = 1) or down the column (blur_direction = 0). Results leave on
// the result channel (result_valid, result_stall) with the centre coordinates,
// only for centres inside the border and the configured row band.
// Throughput is one pixel per cycle unless result_stall holds the pipeline: the
// column line store is read once and written back once per pixel, and its single
// port pair sets that rate. A pixel passes through the store read, the tap sum
// and the reciprocal divide into the output register. A stalled receiver holds
// the output register; the pipeline keeps taking pixels until every stage is full,
// then raises pixel_stall.
// Reset clears the counters, the row window and the pipeline valid bits and
// loads the register defaults; the line store is not cleared, and column mode
// emits results only from entries written earlier in the frame.
// Registers (APB, byte address 4*i): direction, width, first line, end line.
module box_blur_nine_tap_line_or_column (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [bbl_pkg::ADDR_W-1:0] paddr,
	input  logic [bbl_pkg::DATA_W-1:0] pwdata,
	output logic [bbl_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	input  logic                       pixel_valid,
	output logic                       pixel_stall,
	input  logic [7:0]                 channel_0,
	input  logic [7:0]                 channel_1,
	input  logic [7:0]                 channel_2,
	input  logic                       start_of_frame,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic [7:0]                 out_channel_0,
	output logic [7:0]                 out_channel_1,
	output logic [7:0]                 out_channel_2,
	output logic [bbl_pkg::COL_W-1:0]  out_column,
	output logic [bbl_pkg::ROW_W-1:0]  out_row
);
	import bbl_pkg::*;

	cfg_t cfg;

	bbl_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// position and row window
	col_t              col_q;
	row_t              row_q;
	logic [SLOT_W-1:0] slot_q;
	word_t             win_q;

	// stage 1: store read returned
	logic              v_s1;
	pix_t              px_s1;
	col_t              col_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic              emit_s1;
	logic              dir_s1;
	col_t              cx_s1;
	row_t              cy_s1;
	word_t             win_s1;

	// stage 2: tap sums
	logic              v_s2;
	sum_t              sum0_s2, sum1_s2, sum2_s2;
	col_t              cx_s2;
	row_t              cy_s2;

	// output register
	logic              res_v_q;
	logic [CH_W-1:0]   res0_q, res1_q, res2_q;
	col_t              cx_q;
	row_t              cy_q;

	// flow control
	logic en3, en2, en1, accept;

	assign en3         = !res_v_q || !result_stall;
	assign en2         = !v_s2 || en3;
	assign en1         = !v_s1 || en2;
	assign pixel_stall = !en1;
	assign accept      = pixel_valid && en1;

	// stage 0: position, emit decision, coordinates
	pix_t              px;
	col_t              c0;
	row_t              r0;
	logic [SLOT_W-1:0] slot0;
	logic [CMP_W-1:0]  width;
	logic [CMP_W-1:0]  c_w, r_w, cy_w;
	logic              emit_h, emit_v, in_band, emit0, line_end;
	col_t              cx0;
	row_t              cy0;

	assign px    = {channel_2, channel_1, channel_0};
	assign c0    = start_of_frame ? '0 : col_q;
	assign r0    = start_of_frame ? '0 : row_q;
	assign slot0 = start_of_frame ? '0 : slot_q;

	always_comb begin
		// line length clamped to [1, MAX_WIDTH]
		if (cfg.image_width == '0) begin
			width = CMP_W'(1);
		end else if (CMP_W'(cfg.image_width) > CMP_W'(MAX_WIDTH)) begin
			width = CMP_W'(MAX_WIDTH);
		end else begin
			width = CMP_W'(cfg.image_width);
		end
		c_w = CMP_W'(c0);
		r_w = CMP_W'(r0);

		emit_h = (c_w >= CMP_W'(SPAN)) && (c_w < width);
		emit_v = (r_w >= CMP_W'(SPAN)) && (c_w + CMP_W'(RADIUS + 1) <= width)
			&& (c_w >= CMP_W'(RADIUS));

		if (cfg.blur_direction) begin
			cx0 = c0 - COL_W'(RADIUS);
			cy0 = r0;
		end else begin
			cx0 = c0;
			cy0 = r0 - ROW_W'(RADIUS);
		end
		cy_w = CMP_W'(cy0);

		in_band = (cy_w >= CMP_W'(cfg.first_line) + CMP_W'(RADIUS))
			&& (cy_w + CMP_W'(RADIUS + 1) <= CMP_W'(cfg.end_line));
		emit0 = (cfg.blur_direction ? emit_h : emit_v) && in_band;

		line_end = (c_w + CMP_W'(1) >= width);
	end

	// position counters and row window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			slot_q <= '0;
			win_q  <= '0;
		end else if (accept) begin
			win_q <= {win_q[WORD_W-PIX_W-1:0], px};
			if (line_end) begin
				col_q <= '0;
				if (r0 == ROW_W'(MAX_HEIGHT - 1)) begin
					row_q  <= '0;
					slot_q <= '0;
				end else begin
					row_q  <= r0 + ROW_W'(1);
					slot_q <= (slot0 == SLOT_W'(SPAN - 1)) ? '0 : slot0 + SLOT_W'(1);
				end
			end else begin
				col_q  <= c0 + COL_W'(1);
				row_q  <= r0;
				slot_q <= slot0;
			end
		end
	end

	// line store read-modify-write
	word_t store_word;
	word_t wb_word;
	word_t taps;
	logic  wb_en;

	assign wb_en = v_s1 && en2;

	always_comb begin
		wb_word = store_word;
		wb_word[slot_s1*PIX_W +: PIX_W] = px_s1;
	end

	bbl_line_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (c0),
		.wr_en   (wb_en),
		.wr_addr (col_s1),
		.wr_data (wb_word),
		.rd_data (store_word)
	);

	// stage 1 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1   <= px;
			col_s1  <= c0;
			slot_s1 <= slot0;
			emit_s1 <= emit0;
			dir_s1  <= cfg.blur_direction;
			cx_s1   <= cx0;
			cy_s1   <= cy0;
			win_s1  <= win_q;
		end
	end

	// stage 1: sum the centre with the eight taps of the chosen direction
	assign taps = dir_s1 ? win_s1 : store_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			sum0_s2 <= chan_sum(px_s1, taps, 0);
			sum1_s2 <= chan_sum(px_s1, taps, 1);
			sum2_s2 <= chan_sum(px_s1, taps, 2);
			cx_s2   <= cx_s1;
			cy_s2   <= cy_s1;
		end
	end

	// stage 2: divide by nine into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (en3) begin
			res_v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			res0_q <= div_taps(sum0_s2);
			res1_q <= div_taps(sum1_s2);
			res2_q <= div_taps(sum2_s2);
			cx_q   <= cx_s2;
			cy_q   <= cy_s2;
		end
	end

	assign result_valid  = res_v_q;
	assign out_channel_0 = res0_q;
	assign out_channel_1 = res1_q;
	assign out_channel_2 = res2_q;
	assign out_column    = cx_q;
	assign out_row       = cy_q;

endmodule

### hdl/bbl_cfg_regs.sv
// APB register file holding direction, line width and row band.
module bbl_cfg_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [bbl_pkg::ADDR_W-1:0] paddr,
	input  logic [bbl_pkg::DATA_W-1:0] pwdata,
	output logic [bbl_pkg::DATA_W-1:0] prdata,
	output logic                      pready,
	output bbl_pkg::cfg_t             cfg
);
	import bbl_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.blur_direction <= 1'b1;
			cfg_q.image_width    <= IW_W'(MAX_WIDTH);
			cfg_q.first_line     <= '0;
			cfg_q.end_line       <= LINE_W'(4096);
		end else if (wr_en) begin
			case (idx)
				REG_DIRECTION:  cfg_q.blur_direction <= pwdata[0];
				REG_WIDTH:      cfg_q.image_width    <= pwdata[IW_W-1:0];
				REG_FIRST_LINE: cfg_q.first_line     <= pwdata[LINE_W-1:0];
				REG_END_LINE:   cfg_q.end_line       <= pwdata[LINE_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (idx)
			REG_DIRECTION:  prdata = DATA_W'(cfg_q.blur_direction);
			REG_WIDTH:      prdata = DATA_W'(cfg_q.image_width);
			REG_FIRST_LINE: prdata = DATA_W'(cfg_q.first_line);
			REG_END_LINE:   prdata = DATA_W'(cfg_q.end_line);
			default:        prdata = '0;
		endcase
	end

endmodule

### hdl/bbl_line_store.sv
// Column-indexed line store: one word holds the last SPAN pixels of a column.
module bbl_line_store (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  bbl_pkg::col_t       rd_addr,
	input  logic                wr_en,
	input  bbl_pkg::col_t       wr_addr,
	input  bbl_pkg::word_t      wr_data,
	output bbl_pkg::word_t      rd_data
);
	import bbl_pkg::*;

	word_t mem [MAX_WIDTH];
	word_t rd_q;
	word_t fwd_data_q;
	logic  fwd_q;

	// memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q       <= mem[rd_addr];
			fwd_data_q <= wr_data;
		end
	end

	// a read that meets a write-back to the same column takes the new word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = fwd_q ? fwd_data_q : rd_q;

endmodule
